/* hw/rtl/ddbd_pkg.sv */
`default_nettype none
package ddbd_pkg;

   localparam int DATA_W  = 16;
   localparam int BRAKE_W = 15;

   // per-side case picked in the first stage
   typedef enum logic [1:0] {
      MODE_PASS    = 2'd0,   // command at or above speed: duty follows command
      MODE_COAST   = 2'd1,   // positive command below speed: brake = quotient
      MODE_FULL    = 2'd2,   // zero command below speed: full brake
      MODE_REVERSE = 2'd3    // negative command: duty = -quotient
   } mode_type;

endpackage
`default_nettype wire

/* hw/rtl/ddbd_if.sv */
`default_nettype none
interface ddbd_req_if;
   import ddbd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] forward_cmd;
   logic signed [DATA_W-1:0] turn_cmd;
   logic signed [DATA_W-1:0] left_speed;
   logic signed [DATA_W-1:0] right_speed;

   modport source (output valid, forward_cmd, turn_cmd, left_speed, right_speed,
                   input ready);
   modport sink   (input valid, forward_cmd, turn_cmd, left_speed, right_speed,
                   output ready);
endinterface

interface ddbd_rsp_if;
   import ddbd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] left_duty;
   logic        [BRAKE_W-1:0] left_brake;
   logic signed [DATA_W-1:0] right_duty;
   logic        [BRAKE_W-1:0] right_brake;

   modport source (output valid, left_duty, left_brake, right_duty, right_brake,
                   input ready);
   modport sink   (input valid, left_duty, left_brake, right_duty, right_brake,
                   output ready);
endinterface
`default_nettype wire

/* hw/rtl/differential_drive_brake_duty.sv */
`default_nettype none
// Differential-drive duty and brake calculator. Each item on req_ch carries a
// forward and a turn command and the measured speed of each wheel side, all
// signed fixed point with FRAC_BITS fraction bits (1.0 = 2**FRAC_BITS). The
// block forms left = forward - turn and right = forward + turn, clamps each to
// +-1.0, and gives per side a motor duty and a brake duty on rsp_ch. Negative
// speed is mirrored. Above speed the duty follows the command; below speed a
// non-negative command brakes by (speed - cmd) / speed and a negative command
// drives by (cmd - speed) / (1 + speed), both truncated toward zero. One item
// is taken every cycle while rsp_ch does not stall; the pipe has one prep
// stage, one restoring-divider stage per quotient bit, FRAC_BITS + 1 of them,
// and the output register. The divider pipeline, one compare-subtract per
// stage and one per side, sets the depth. A stall on rsp_ch backs up the pipe,
// filling empty stages first; no item is dropped or repeated. Results wider
// than the output fields (only for FRAC_BITS above 14) carry the low bits.
module differential_drive_brake_duty #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ddbd_req_if.sink   req_ch,
   ddbd_rsp_if.source rsp_ch
);
   import ddbd_pkg::*;

   // working width: holds +-(2**FRAC_BITS + 2**15) with room to spare
   localparam int SW   = ((FRAC_BITS > DATA_W) ? FRAC_BITS : DATA_W) + 3;
   localparam int DW   = SW - 1;             // unsigned remainder / divisor
   localparam int QW   = FRAC_BITS + 1;      // quotient lies in 0..ONE
   localparam int BW   = (QW > BRAKE_W) ? QW : BRAKE_W;
   localparam int P    = FRAC_BITS + 1;      // divider stages
   localparam int LAST = P + 1;              // output register stage

   localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;
   localparam logic        [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

   // ---------------------------------------------------------------------
   // Flow control: each stage loads when it is empty or its successor moves.
   // ---------------------------------------------------------------------
   logic [LAST:0]   v_ff;
   logic [LAST:0]   v_in;
   logic [LAST+1:0] rdy;

   assign rdy[LAST+1] = rsp_ch.ready;
   assign v_in        = {v_ff[LAST-1:0], req_ch.valid};

   for (genvar i = 0; i <= LAST; i++) begin : g_rdy
      assign rdy[i] = !v_ff[i] || rdy[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i <= LAST; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   assign req_ch.ready = rdy[0];
   assign rsp_ch.valid = v_ff[LAST];

   // ---------------------------------------------------------------------
   // Side commands: index 0 is left, 1 is right.
   // ---------------------------------------------------------------------
   logic signed [SW-1:0] fwd_x;
   logic signed [SW-1:0] trn_x;
   logic signed [SW-1:0] cmd_raw [2];
   logic signed [SW-1:0] speed_x [2];

   assign fwd_x      = SW'(req_ch.forward_cmd);
   assign trn_x      = SW'(req_ch.turn_cmd);
   assign cmd_raw[0] = fwd_x - trn_x;
   assign cmd_raw[1] = fwd_x + trn_x;
   assign speed_x[0] = SW'(req_ch.left_speed);
   assign speed_x[1] = SW'(req_ch.right_speed);

   logic [DATA_W-1:0]  duty_ff  [2];
   logic [BRAKE_W-1:0] brake_ff [2];

   for (genvar sd = 0; sd < 2; sd++) begin : g_side
      // stage 0 .. P carry the case info; the divider state stops earlier
      logic        [DW-1:0] rem_ff  [P];
      logic        [DW-1:0] den_ff  [P];
      logic        [QW-1:0] q_ff    [1:P];
      mode_type             mode_ff [P+1];
      logic                 mirr_ff [P+1];
      logic signed [SW-1:0] cmd_ff  [P+1];

      // ---- stage 0: clamp, mirror, pick the case, set up the division ----
      logic signed [SW-1:0] c_val;
      logic signed [SW-1:0] s_val;
      logic                 mirr_in;
      mode_type             mode_in;
      logic        [DW-1:0] rem_in;
      logic        [DW-1:0] den_in;

      always_comb begin
         c_val = cmd_raw[sd];
         if (c_val > ONE_S) begin
            c_val = ONE_S;
         end else if (c_val < -ONE_S) begin
            c_val = -ONE_S;
         end
         s_val   = speed_x[sd];
         mirr_in = s_val < 0;
         if (mirr_in) begin
            c_val = -c_val;
            s_val = -s_val;
         end
         if (c_val >= s_val) begin
            mode_in = MODE_PASS;
         end else if (c_val > 0) begin
            mode_in = MODE_COAST;
         end else if (c_val == 0) begin
            mode_in = MODE_FULL;
         end else begin
            mode_in = MODE_REVERSE;
         end
         // both division cases share the numerator speed - cmd, and it never
         // exceeds the divisor, so the quotient fits FRAC_BITS + 1 bits
         rem_in = DW'(s_val - c_val);
         den_in = (c_val < 0) ? DW'(ONE_S + s_val) : DW'(s_val);
      end

      always_ff @(posedge clock) begin
         if (rdy[0]) begin
            rem_ff[0]  <= rem_in;
            den_ff[0]  <= den_in;
            mode_ff[0] <= mode_in;
            mirr_ff[0] <= mirr_in;
            cmd_ff[0]  <= c_val;
         end
      end

      // ---- stages 1..P: restoring division, one quotient bit per stage ----
      for (genvar k = 1; k <= P; k++) begin : g_div
         logic [DW:0]   trial;
         logic          q_bit;
         logic [QW-1:0] q_in;

         if (k == 1) begin : g_first
            assign trial = {1'b0, rem_ff[k-1]};
            assign q_in  = QW'(q_bit);
         end else begin : g_next
            assign trial = {rem_ff[k-1], 1'b0};
            assign q_in  = {q_ff[k-1][QW-2:0], q_bit};
         end

         assign q_bit = trial >= {1'b0, den_ff[k-1]};

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               q_ff[k]    <= q_in;
               mode_ff[k] <= mode_ff[k-1];
               mirr_ff[k] <= mirr_ff[k-1];
               cmd_ff[k]  <= cmd_ff[k-1];
            end
         end

         if (k < P) begin : g_carry
            logic [DW:0] diff;

            assign diff = q_bit ? (trial - {1'b0, den_ff[k-1]}) : trial;

            // remainder stays below the divisor, so DW bits hold it
            always_ff @(posedge clock) begin
               if (rdy[k]) begin
                  rem_ff[k] <= diff[DW-1:0];
                  den_ff[k] <= den_ff[k-1];
               end
            end
         end
      end

      // ---- output stage: select duty / brake, undo the mirror ----
      logic signed [SW-1:0] duty_x;
      logic signed [SW-1:0] duty_s;
      logic        [BW-1:0] brake_w;

      always_comb begin
         case (mode_ff[P])
            MODE_PASS: begin
               duty_x  = cmd_ff[P];
               brake_w = '0;
            end
            MODE_COAST: begin
               duty_x  = '0;
               brake_w = BW'(q_ff[P]);
            end
            MODE_FULL: begin
               duty_x  = '0;
               brake_w = BW'(ONE_Q);
            end
            MODE_REVERSE: begin
               duty_x  = -$signed(SW'(q_ff[P]));
               brake_w = '0;
            end
            default: begin
               duty_x  = '0;
               brake_w = '0;
            end
         endcase
         duty_s = mirr_ff[P] ? -duty_x : duty_x;
      end

      always_ff @(posedge clock) begin
         if (rdy[LAST]) begin
            duty_ff[sd]  <= duty_s[DATA_W-1:0];
            brake_ff[sd] <= brake_w[BRAKE_W-1:0];
         end
      end
   end

   assign rsp_ch.left_duty   = $signed(duty_ff[0]);
   assign rsp_ch.left_brake  = brake_ff[0];
   assign rsp_ch.right_duty  = $signed(duty_ff[1]);
   assign rsp_ch.right_brake = brake_ff[1];

endmodule
`default_nettype wire

/* hw/rtl/ddbd_checker.sv */
`default_nettype none
module ddbd_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [ddbd_pkg::DATA_W-1:0]  left_duty,
   input wire logic        [ddbd_pkg::BRAKE_W-1:0] left_brake,
   input wire logic signed [ddbd_pkg::DATA_W-1:0]  right_duty,
   input wire logic        [ddbd_pkg::BRAKE_W-1:0] right_brake
);
   import ddbd_pkg::*;

   // output held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_duty) && $stable(left_brake)
                                  && $stable(right_duty) && $stable(right_brake))
      else $error("result changed while stalled");

   // pipe drains after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a consumer that takes results keeps the input open
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

   // braking and driving never overlap on a side
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (left_brake == '0 || left_duty == '0)
                    && (right_brake == '0 || right_duty == '0))
      else $error("brake and duty both active on one side");

endmodule

bind differential_drive_brake_duty ddbd_checker u_ddbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .left_duty   (rsp_ch.left_duty),
   .left_brake  (rsp_ch.left_brake),
   .right_duty  (rsp_ch.right_duty),
   .right_brake (rsp_ch.right_brake)
);
`default_nettype wire

/* verif/differential_drive_brake_duty_checker.sv */
module differential_drive_brake_duty_checker #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   ddbd_req_if       req_mon,
   ddbd_rsp_if       rsp_mon,
   output int        errors,
   output int        outstanding
);
   import ddbd_pkg::*;

   localparam longint ONE       = longint'(1) << FRAC_BITS;
   localparam int     MAX_PRINT = 100;

   typedef struct {
      logic signed [DATA_W-1:0]  left_duty;
      logic        [BRAKE_W-1:0] left_brake;
      logic signed [DATA_W-1:0]  right_duty;
      logic        [BRAKE_W-1:0] right_brake;
      mode_type                  left_mode;
      mode_type                  right_mode;
   } duty_brake_type;

   duty_brake_type duty_brake_q[$];
   int             mismatch_count = 0;
   int             queued_count   = 0;
   int             result_index   = 0;

   assign errors      = mismatch_count;
   assign outstanding = queued_count;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINT)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // one wheel side; negative speed is handled by mirroring both values
   function automatic mode_type wheel_duty(input longint cmd, input longint spd,
                                           output longint duty, output longint brake);
      longint   c;
      longint   s;
      longint   d;
      bit       mirrored;
      mode_type mode;
      c        = cmd;
      s        = spd;
      d        = 0;
      brake    = 0;
      mirrored = 1'b0;
      if (s < 0) begin
         mirrored = 1'b1;
         c        = -c;
         s        = -s;
      end
      if (c >= s) begin
         mode = MODE_PASS;
         d    = c;
      end else if (c > 0) begin
         mode  = MODE_COAST;
         brake = ((s - c) * ONE) / s;
      end else if (c == 0) begin
         mode  = MODE_FULL;
         brake = ONE;
      end else begin
         mode = MODE_REVERSE;
         d    = ((c - s) * ONE) / (ONE + s);
      end
      duty = mirrored ? -d : d;
      return mode;
   endfunction

   function automatic duty_brake_type predict_duty_brake(input longint fwd, input longint trn,
                                                          input longint lspd,
                                                          input longint rspd);
      duty_brake_type r;
      longint         lcmd;
      longint         rcmd;
      longint         duty;
      longint         brake;
      lcmd = fwd - trn;
      rcmd = fwd + trn;
      if (lcmd > ONE) lcmd = ONE;
      if (lcmd < -ONE) lcmd = -ONE;
      if (rcmd > ONE) rcmd = ONE;
      if (rcmd < -ONE) rcmd = -ONE;
      r.left_mode   = wheel_duty(lcmd, lspd, duty, brake);
      r.left_duty   = duty[DATA_W-1:0];
      r.left_brake  = brake[BRAKE_W-1:0];
      r.right_mode  = wheel_duty(rcmd, rspd, duty, brake);
      r.right_duty  = duty[DATA_W-1:0];
      r.right_brake = brake[BRAKE_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                              input logic [DATA_W-1:0] want, input mode_type mode);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %h, expected %h (%s)",
                                   result_index, name, got, want, mode.name()));
   endtask

   always @(posedge clock) begin
      duty_brake_type want;
      if (reset) begin
         duty_brake_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            duty_brake_q.push_back(predict_duty_brake(longint'(req_mon.forward_cmd),
                                                      longint'(req_mon.turn_cmd),
                                                      longint'(req_mon.left_speed),
                                                      longint'(req_mon.right_speed)));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (duty_brake_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_index));
            end else begin
               want = duty_brake_q.pop_front();
               check_field("left_duty", rsp_mon.left_duty, want.left_duty, want.left_mode);
               check_field("left_brake", DATA_W'(rsp_mon.left_brake),
                           DATA_W'(want.left_brake), want.left_mode);
               check_field("right_duty", rsp_mon.right_duty, want.right_duty,
                           want.right_mode);
               check_field("right_brake", DATA_W'(rsp_mon.right_brake),
                           DATA_W'(want.right_brake), want.right_mode);
            end
            result_index++;
         end
      end
      queued_count = duty_brake_q.size();
   end

endmodule

/* verif/differential_drive_brake_duty_tb.sv */
module differential_drive_brake_duty_tb;
   import ddbd_pkg::*;

   localparam int FRAC_BITS      = 14;
   localparam int ONE            = 1 << FRAC_BITS;
   // prep stage + FRAC_BITS+1 divider stages + output register
   localparam int LATENCY        = FRAC_BITS + 3;
   // long receiver hold-off, enough to fill the pipe and back up the input
   localparam int HOLD_OFF       = 300;
   // cycles with no item moving on either channel before giving up
   localparam int WATCHDOG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddbd_req_if req_ch ();
   ddbd_rsp_if rsp_ch ();

   // idle/stall odds in percent, changed per phase by the stimulus process
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   // hold-off handshake with the receiver process: bump to ask for one
   int hold_requests   = 0;
   int hold_served     = 0;
   int quiet_cycles    = 0;
   int errors;
   int outstanding;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   differential_drive_brake_duty #(
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   differential_drive_brake_duty_checker #(
      .FRAC_BITS (FRAC_BITS)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .errors      (errors),
      .outstanding (outstanding)
   );

   // Offer one item, with random idle cycles ahead of it. Called and returns
   // at a falling edge; valid is written once per edge at most.
   task automatic send_command(input int fwd, input int trn, input int lspd, input int rspd);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.forward_cmd <= DATA_W'(fwd);
      req_ch.turn_cmd    <= DATA_W'(trn);
      req_ch.left_speed  <= DATA_W'(lspd);
      req_ch.right_speed <= DATA_W'(rspd);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly nominal -1..1, some exact extremes, some raw 16-bit patterns
   function automatic int pick_command();
      case ($urandom_range(9))
         0: return int'($urandom_range(65535)) - 32768;
         1: begin
            case ($urandom_range(2))
               0:       return -ONE;
               1:       return 0;
               default: return ONE;
            endcase
         end
         default: return int'($urandom_range(2 * ONE)) - ONE;
      endcase
   endfunction

   // full range, near zero (tiny divisors), exact extremes, and the nominal band
   function automatic int pick_speed();
      case ($urandom_range(9))
         0, 1, 2: return int'($urandom_range(65535)) - 32768;
         3:       return int'($urandom_range(128)) - 64;
         4: begin
            case ($urandom_range(4))
               0:       return -32768;
               1:       return 32767;
               2:       return ONE;
               3:       return -ONE;
               default: return 0;
            endcase
         end
         default: return int'($urandom_range(40000)) - 20000;
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_command(pick_command(), pick_command(), pick_speed(), pick_speed());
   endtask

   // Receiver: random stalls at the current odds; on request, one long
   // hold-off counted here while the sender keeps offering.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
            hold_served = hold_requests;
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: any accepted item on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.forward_cmd = '0;
      req_ch.turn_cmd    = '0;
      req_ch.left_speed  = '0;
      req_ch.right_speed = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed items, no idling ---
      send_command(0, 0, 0, 0);                  // all zero: pass-through
      send_command(ONE, 0, 0, 0);                // full forward, speeding up
      send_command(ONE, 0, ONE, ONE);            // command equal to speed
      send_command(0, 0, ONE, ONE);              // zero command below speed: full brake
      send_command(ONE / 2, 0, ONE, 32767);      // coasting brake quotient
      send_command(-ONE, 0, ONE, 32767);         // reverse drive, divisor 1+speed
      send_command(0, 0, -ONE, -32768);          // mirrored full brake, most negative speed
      send_command(-ONE / 2, 0, -ONE, -32768);   // mirrored coast
      send_command(ONE, 0, -ONE, -1);            // mirrored reverse
      send_command(-ONE, 0, -ONE, -ONE);         // mirrored, command equal to speed
      send_command(ONE, ONE, 0, 0);              // right sum clamps to +1
      send_command(ONE, -ONE, 0, 0);             // left difference clamps to +1
      send_command(-ONE, ONE, 0, 0);             // left clamps to -1
      send_command(-ONE, -ONE, 0, 0);            // right clamps to -1
      send_command(32767, -32768, 100, -100);    // commands far out of range
      send_command(-32768, -32768, 32767, -32768);
      send_command(32767, 32767, -32768, 32767);
      send_command(1, 0, 2, 2);                  // tiny coast
      send_command(-1, 0, 1, 1);                 // tiny reverse
      send_command(0, 1, 1, -1);
      send_command(ONE / 2, -ONE / 4, 12000, -3000);
      send_command(-ONE / 4, ONE / 2, 32767, -32768);
      send_command(0, 0, 32767, 1);              // brake with smallest positive speed
      send_command(-1, 1, 16'hAAAA, 16'h5555);   // alternating bit patterns
      send_command(16'h5555, 16'hAAAA, -1, 16'h7FFE);

      // --- random phases ---
      send_random(200);                          // no idling
      sender_idle_pct = 80;
      send_random(200);                          // sparse sender
      sender_idle_pct = 0;
      stall_pct       = 80;
      send_random(200);                          // slow receiver
      sender_idle_pct = 7;
      stall_pct       = 7;
      send_random(150);                          // light idling on both sides

      // backpressure: receiver holds off long, sender streams until blocked
      sender_idle_pct = 0;
      stall_pct       = 0;
      hold_requests++;
      send_random(100);

      req_ch.valid <= 1'b0;
      wait (outstanding == 0);
      // catch any stray result still coming down the pipe
      repeat (LATENCY + 8) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
